FILE: rtl/uart_frame_encoder_macros.svh
// Assertion macros used by the frame encoder back end.
`ifndef UART_FRAME_ENCODER_MACROS_SVH
`define UART_FRAME_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define UFE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("frame encoder assertion failed");
`define UFE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("frame encoder forbidden condition seen");
`else
`define UFE_ASSERT(lbl, clk, rstn, prop)
`define UFE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: rtl/uenc_pkg.sv
// Types, constants and the CRC step shared by the frame encoder modules.
package uenc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned HdrBytes   = 16;
  localparam int unsigned AddrWidth  = 5;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcTopBit  = 16'h8000;

  typedef enum logic [2:0] {
    REG_FLAG    = 3'd0,
    REG_ESCAPE  = 3'd1,
    REG_MASK    = 3'd2,
    REG_VERSION = 3'd3,
    REG_TYPE_LO = 3'd4,
    REG_TYPE_HI = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_VERSION = 3'd1,
    STATUS_BAD_TYPE    = 3'd2,
    STATUS_TOO_LONG    = 3'd3,
    STATUS_NO_FRAME    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_ERROR  = 2'd2
  } cmd_kind_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_OPEN   = 3'd1,
    S_HEADER = 3'd2,
    S_DATA   = 3'd3,
    S_CRC_LO = 3'd4,
    S_CRC_HI = 3'd5,
    S_CLOSE  = 3'd6,
    S_ERROR  = 3'd7
  } enc_state_e;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] mask;
    logic [7:0] version;
    logic [7:0] type_lo;
    logic [7:0] type_hi;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        close;
    status_e     status;
    logic [7:0]  version;
    logic [7:0]  msg_kind;
    logic [8:0]  count;
    logic [31:0] seq;
    logic [31:0] boot;
    logic [31:0] uptime;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTopBit) != 16'h0000) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/uenc_regs.sv
// Configuration register bank behind the APB-style port.
module uenc_regs
  import uenc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e sel;
  logic     wr_en;

  assign sel   = reg_idx_e'(paddr[AddrWidth-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_FLAG:    cfg_d.flag    = pwdata[7:0];
        REG_ESCAPE:  cfg_d.escape  = pwdata[7:0];
        REG_MASK:    cfg_d.mask    = pwdata[7:0];
        REG_VERSION: cfg_d.version = pwdata[7:0];
        REG_TYPE_LO: cfg_d.type_lo = pwdata[7:0];
        REG_TYPE_HI: cfg_d.type_hi = pwdata[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_FLAG:    prdata = {24'd0, cfg_q.flag};
      REG_ESCAPE:  prdata = {24'd0, cfg_q.escape};
      REG_MASK:    prdata = {24'd0, cfg_q.mask};
      REG_VERSION: prdata = {24'd0, cfg_q.version};
      REG_TYPE_LO: prdata = {24'd0, cfg_q.type_lo};
      REG_TYPE_HI: prdata = {24'd0, cfg_q.type_hi};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag    <= 8'h7E;
      cfg_q.escape  <= 8'h7D;
      cfg_q.mask    <= 8'h20;
      cfg_q.version <= 8'h01;
      cfg_q.type_lo <= 8'h01;
      cfg_q.type_hi <= 8'h08;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/uenc_front.sv
// Front end: accepts requests, checks headers and tracks the open frame.
module uenc_front
  import uenc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  version_i,
  input  logic [7:0]  message_kind_i,
  input  logic [8:0]  payload_count_i,
  input  logic [31:0] sequence_number_i,
  input  logic [31:0] boot_identifier_i,
  input  logic [31:0] uptime_ms_i,
  input  logic [7:0]  data_byte_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic       frame_open_q, frame_open_d;
  logic [8:0] remaining_q, remaining_d;
  status_e    hdr_status;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    if (version_i != cfg_i.version) begin
      hdr_status = STATUS_BAD_VERSION;
    end else if (message_kind_i < cfg_i.type_lo || message_kind_i > cfg_i.type_hi) begin
      hdr_status = STATUS_BAD_TYPE;
    end else if (32'(payload_count_i) > 32'(MAX_PAYLOAD)) begin
      hdr_status = STATUS_TOO_LONG;
    end else begin
      hdr_status = STATUS_OK;
    end
  end

  always_comb begin
    frame_open_d     = frame_open_q;
    remaining_d      = remaining_q;
    cmd_o.kind       = CMD_ERROR;
    cmd_o.close      = 1'b0;
    cmd_o.status     = STATUS_OK;
    cmd_o.version    = version_i;
    cmd_o.msg_kind   = message_kind_i;
    cmd_o.count      = payload_count_i;
    cmd_o.seq        = sequence_number_i;
    cmd_o.boot       = boot_identifier_i;
    cmd_o.uptime     = uptime_ms_i;
    cmd_o.data       = data_byte_i;
    if (!operation_i) begin
      if (hdr_status != STATUS_OK) begin
        cmd_o.status = hdr_status;
        frame_open_d = 1'b0;
        remaining_d  = 9'd0;
      end else begin
        cmd_o.kind   = CMD_HEADER;
        cmd_o.close  = (payload_count_i == 9'd0);
        frame_open_d = (payload_count_i != 9'd0);
        remaining_d  = payload_count_i;
      end
    end else begin
      if (!frame_open_q || remaining_q == 9'd0) begin
        cmd_o.status = STATUS_NO_FRAME;
      end else begin
        cmd_o.kind  = CMD_DATA;
        cmd_o.close = (remaining_q == 9'd1);
        remaining_d = remaining_q - 9'd1;
        if (remaining_q == 9'd1) begin
          frame_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      remaining_q  <= 9'd0;
    end else if (push_o) begin
      frame_open_q <= frame_open_d;
      remaining_q  <= remaining_d;
    end
  end

endmodule

FILE: rtl/uenc_fifo.sv
// Short command queue between the front end and the byte sequencer.
module uenc_fifo
  import uenc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/uenc_back.sv
// Back end: walks each command into stuffed wire bytes, CRC and flags, or an error result.
`include "uart_frame_encoder_macros.svh"

module uenc_back
  import uenc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       frame_end_o,
  output logic       last_of_run_o,
  output logic [2:0] status_o
);

  localparam int unsigned IdxW = $clog2(HdrBytes);
  localparam logic [IdxW-1:0] HdrLast = IdxW'(HdrBytes - 1);

  enc_state_e      state_q, state_d, next_cmd_state;
  cmd_t            cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            esc_q, esc_d;
  logic [15:0]     crc_q, crc_d;

  logic            out_valid_q;
  logic [7:0]      byte_q;
  logic            bvalid_q, fend_q, last_q;
  status_e         status_q;

  logic            adv, emit, done;
  logic [7:0]      e_byte;
  logic            e_valid, e_fend, e_last;
  status_e         e_status;
  logic [127:0]    hdr_vec;
  logic [7:0]      cur_byte;
  logic            stuffable, needs_esc, complete;

  function automatic enc_state_e start_state(cmd_kind_e k);
    enc_state_e s;
    case (k)
      CMD_HEADER: s = S_OPEN;
      CMD_DATA:   s = S_DATA;
      default:    s = S_ERROR;
    endcase
    return s;
  endfunction

  assign adv     = !out_valid_q || out_ready_i;
  assign hdr_vec = {cmd_q.uptime, cmd_q.boot, cmd_q.seq, 7'd0, cmd_q.count,
                    cmd_q.msg_kind, cmd_q.version};

  always_comb begin
    case (state_q)
      S_HEADER: cur_byte = hdr_vec[{idx_q, 3'b000} +: 8];
      S_DATA:   cur_byte = cmd_q.data;
      S_CRC_LO: cur_byte = crc_q[7:0];
      S_CRC_HI: cur_byte = crc_q[15:8];
      default:  cur_byte = cfg_i.flag;
    endcase
  end

  assign stuffable = (state_q == S_HEADER) || (state_q == S_DATA) ||
                     (state_q == S_CRC_LO) || (state_q == S_CRC_HI);
  assign needs_esc = stuffable && (cur_byte == cfg_i.flag || cur_byte == cfg_i.escape);
  assign complete  = !needs_esc || esc_q;
  assign next_cmd_state = q_valid_i ? start_state(head_i.kind) : S_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = start_state(head_i.kind);
        end
      end
      S_OPEN: begin
        if (adv) begin
          state_d = S_HEADER;
        end
      end
      S_HEADER: begin
        if (adv && complete && idx_q == HdrLast) begin
          state_d = cmd_q.close ? S_CRC_LO : next_cmd_state;
        end
      end
      S_DATA: begin
        if (adv && complete) begin
          state_d = cmd_q.close ? S_CRC_LO : next_cmd_state;
        end
      end
      S_CRC_LO: begin
        if (adv && complete) begin
          state_d = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (adv && complete) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE, S_ERROR: begin
        if (adv) begin
          state_d = next_cmd_state;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    done     = 1'b0;
    pop_o    = 1'b0;
    e_byte   = 8'd0;
    e_valid  = 1'b0;
    e_fend   = 1'b0;
    e_last   = 1'b0;
    e_status = STATUS_OK;
    idx_d    = idx_q;
    esc_d    = esc_q;
    crc_d    = crc_q;
    cmd_d    = cmd_q;
    unique case (state_q)
      S_IDLE: begin
        pop_o = q_valid_i;
      end
      S_OPEN: begin
        if (adv) begin
          emit    = 1'b1;
          e_byte  = cfg_i.flag;
          e_valid = 1'b1;
          crc_d   = CrcInit;
          idx_d   = '0;
        end
      end
      S_HEADER, S_DATA, S_CRC_LO, S_CRC_HI: begin
        if (adv) begin
          emit    = 1'b1;
          e_valid = 1'b1;
          if (needs_esc && !esc_q) begin
            e_byte = cfg_i.escape;
          end else if (esc_q) begin
            e_byte = cur_byte ^ cfg_i.mask;
          end else begin
            e_byte = cur_byte;
          end
          if ((state_q == S_HEADER || state_q == S_DATA) && !esc_q) begin
            crc_d = crc_update(crc_q, cur_byte);
          end
          esc_d = !complete;
          if (complete) begin
            if (state_q == S_HEADER) begin
              idx_d = idx_q + 1'b1;
              if (idx_q == HdrLast && !cmd_q.close) begin
                e_last = 1'b1;
                done   = 1'b1;
              end
            end else if (state_q == S_DATA && !cmd_q.close) begin
              e_last = 1'b1;
              done   = 1'b1;
            end
          end
        end
      end
      S_CLOSE: begin
        if (adv) begin
          emit    = 1'b1;
          e_byte  = cfg_i.flag;
          e_valid = 1'b1;
          e_fend  = 1'b1;
          e_last  = 1'b1;
          crc_d   = CrcInit;
          done    = 1'b1;
        end
      end
      S_ERROR: begin
        if (adv) begin
          emit     = 1'b1;
          e_last   = 1'b1;
          e_status = cmd_q.status;
          done     = 1'b1;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
    if (done) begin
      pop_o = q_valid_i;
    end
    if (pop_o) begin
      cmd_d = head_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      byte_q   <= e_byte;
      bvalid_q <= e_valid;
      fend_q   <= e_fend;
      last_q   <= e_last;
      status_q <= e_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      esc_q       <= 1'b0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      esc_q   <= esc_d;
      crc_q   <= crc_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bvalid_q;
  assign frame_end_o   = fend_q;
  assign last_of_run_o = last_q;
  assign status_o      = status_q;

  `UFE_ASSERT(a_pop_needs_entry, clk_i, rst_ni, pop_o |-> q_valid_i)
  `UFE_ASSERT(a_idx_only_in_header, clk_i, rst_ni, (idx_q != '0) |-> (state_q == S_HEADER))
  `UFE_ASSERT(a_crc_reinit_on_close, clk_i, rst_ni, (state_q == S_CLOSE && adv) |=> (crc_q == CrcInit))
  `UFE_ASSERT_NEVER(a_escape_outside_bytes, clk_i, rst_ni, esc_q && !(state_q == S_HEADER || state_q == S_DATA || state_q == S_CRC_LO || state_q == S_CRC_HI))

endmodule

FILE: rtl/uart_frame_encoder.sv
// Top level of the byte-stuffed frame encoder with CRC-16.
//
//   channel  direction  handshake                      payload
//   in       sink       in_valid_i / in_ready_o        operation_i .. data_byte_i
//   out      source     out_valid_o / out_ready_i      out_byte_o .. status_o
//   cfg      sink       psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One result leaves per cycle while out_ready_i is high and the sequencer is busy; the byte sequencer sets the rate.
// A valid header gives 17 to 38 results, an error 1, a payload byte 1 to 2,
// or 4 to 7 when it closes the frame.
// Requests enter at one per cycle into a four-entry command queue; in_ready_o drops when full.
// A command that finds the sequencer idle is first loaded in S_IDLE, else it starts straight after the previous one.
// Reset is asynchronous and needs no clearing pass; state, pointers and configuration return to their defaults.
module uart_frame_encoder
  import uenc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [7:0]           version_i,
  input  logic [7:0]           message_kind_i,
  input  logic [8:0]           payload_count_i,
  input  logic [31:0]          sequence_number_i,
  input  logic [31:0]          boot_identifier_i,
  input  logic [31:0]          uptime_ms_i,
  input  logic [7:0]           data_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 byte_valid_o,
  output logic                 frame_end_o,
  output logic                 last_of_run_o,
  output logic [2:0]           status_o
);

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic push, full, pop, q_valid;

  assign pready = 1'b1;

  uenc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  uenc_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .version_i         (version_i),
    .message_kind_i    (message_kind_i),
    .payload_count_i   (payload_count_i),
    .sequence_number_i (sequence_number_i),
    .boot_identifier_i (boot_identifier_i),
    .uptime_ms_i       (uptime_ms_i),
    .data_byte_i       (data_byte_i),
    .full_i            (full),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  uenc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head_cmd)
  );

  uenc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .frame_end_o   (frame_end_o),
    .last_of_run_o (last_of_run_o),
    .status_o      (status_o)
  );

endmodule
